[hw/rtl/i2cm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C register access master: command
// codes, sequencer phases, transfer stages, status codes and the words that
// travel between the front end and the bus engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // burst and write queue sizing
    localparam int MAX_BURST = 16;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int QIDX_W    = $clog2(MAX_BURST);

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [1:0] CFG_QUARTER  = 2'd1;
    localparam logic [1:0] CFG_AUTO_INC = 2'd2;

    // bit seven of the register address marks auto increment on reads
    localparam logic [7:0] AUTO_INC_MASK = 8'h80;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_QUEUE = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NACK = 2'd1,
        ST_BUSY = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_START_A    = 5'd1,
        PH_START_B    = 5'd2,
        PH_START_C    = 5'd3,
        PH_BIT_LOW    = 5'd4,
        PH_BIT_SET    = 5'd5,
        PH_BIT_HIGH   = 5'd6,
        PH_ACK_LOW    = 5'd7,
        PH_ACK_REL    = 5'd8,
        PH_ACK_HIGH   = 5'd9,
        PH_ACK_SAMPLE = 5'd10,
        PH_RS_SDA     = 5'd11,
        PH_RB_LOW     = 5'd12,
        PH_RB_HIGH    = 5'd13,
        PH_RB_SAMPLE  = 5'd14,
        PH_AK_LOW     = 5'd15,
        PH_AK_SET     = 5'd16,
        PH_AK_HIGH    = 5'd17,
        PH_AK_END     = 5'd18,
        PH_STOP_A     = 5'd19,
        PH_STOP_B     = 5'd20,
        PH_STOP_C     = 5'd21,
        PH_STOP_D     = 5'd22
    } t_phase;

    typedef enum logic [2:0] {
        STG_ADDR_W = 3'd0,
        STG_REG    = 3'd1,
        STG_ADDR_R = 3'd2,
        STG_WDATA  = 3'd3,
        STG_RDATA  = 3'd4
    } t_stage;

    // classified input word
    typedef struct packed {
        t_cmd               cmd;
        logic               sda;
        logic [7:0]         reg_addr;
        logic [BURST_W-1:0] burst_len;
        logic [7:0]         wbyte;
    } t_item;

    // result word
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rbyte;
        logic       rvalid;
        logic       last;
        logic       done;
        t_status    status;
        logic       busy;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/i2c_master_register_access_top.sv]
// A pushed word is held in the front queue, and its result word in the result queue.
// Throughput: one word per clock on both sides unless a queue fills or pop stalls; every word gives one result.
// The bus engine retires one word per cycle unless the result queue is full; a bus
// step waits for as many tick words as the quarter period register holds.
// Reset (i_rst_n low, synchronous): both queues empty, bus idle, SCL and SDA
// released, configuration at its reset values, write byte queue empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// Bit-level I2C master for device register reads and writes, with a
// classifying front end and a bus engine joined by a short word queue.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    // input words
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_command,
    input  wire logic        i_sda_in,
    input  wire logic [7:0]  i_reg_addr,
    input  wire logic [4:0]  i_burst_length,
    input  wire logic [7:0]  i_write_byte,
    // result words
    output logic             empty,
    input  wire logic        pop,
    output logic             o_scl_out,
    output logic             o_sda_out,
    output logic [7:0]       o_read_byte,
    output logic             o_read_valid,
    output logic             o_last_byte,
    output logic             o_done_res,
    output logic [1:0]       o_status,
    output logic             o_busy_res
);
    import i2cm_pkg::*;

    t_item    w_item;
    logic     w_item_valid;
    logic     w_take;
    t_result  w_res;
    logic     w_res_valid;

    // front end: accept and classify
    i2cm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_command      (i_command),
        .i_sda_in       (i_sda_in),
        .i_reg_addr     (i_reg_addr),
        .i_burst_length (i_burst_length),
        .i_write_byte   (i_write_byte),
        .o_full         (full),
        .o_item         (w_item),
        .o_valid        (w_item_valid),
        .i_take         (w_take)
    );

    // bus engine and result queue
    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_item),
        .i_valid     (w_item_valid),
        .o_take      (w_take),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_pop   (pop)
    );

    // result ports
    assign empty        = !w_res_valid;
    assign o_scl_out    = w_res.scl;
    assign o_sda_out    = w_res.sda;
    assign o_read_byte  = w_res.rbyte;
    assign o_read_valid = w_res.rvalid;
    assign o_last_byte  = w_res.last;
    assign o_done_res   = w_res.done;
    assign o_status     = w_res.status;
    assign o_busy_res   = w_res.busy;

endmodule
`default_nettype wire

[hw/rtl/i2cm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input words, classifies them (saturates the burst length) and
// holds them in a two-entry queue until the bus engine takes them.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [1:0]            i_command,
    input  wire logic                  i_sda_in,
    input  wire logic [7:0]            i_reg_addr,
    input  wire logic [4:0]            i_burst_length,
    input  wire logic [7:0]            i_write_byte,
    output logic                       o_full,
    output i2cm_pkg::t_item            o_item,
    output logic                       o_valid,
    input  wire logic                  i_take
);
    import i2cm_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_cnt;
    t_item       w_item;
    logic        w_push;
    logic        w_pop;

    // classify the incoming word
    always_comb begin
        w_item.cmd      = t_cmd'(i_command);
        w_item.sda      = i_sda_in;
        w_item.reg_addr = i_reg_addr;
        w_item.wbyte    = i_write_byte;
        if (i_burst_length == '0) begin
            w_item.burst_len = BURST_W'(1);
        end else if (BURST_W'(i_burst_length) > BURST_W'(MAX_BURST)) begin
            w_item.burst_len = BURST_W'(MAX_BURST);
        end else begin
            w_item.burst_len = BURST_W'(i_burst_length);
        end
    end

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd_ptr];

    // queue pointers
    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/i2cm_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus engine: configuration registers, write byte queue, the pin level
// sequencer and a two-entry result queue towards the consumer.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_addr,
    input  wire logic [7:0]            i_cfg_wdata,
    input  i2cm_pkg::t_item            i_item,
    input  wire logic                  i_valid,
    output logic                       o_take,
    output i2cm_pkg::t_result          o_res,
    output logic                       o_res_valid,
    input  wire logic                  i_res_pop
);
    import i2cm_pkg::*;

    // configuration
    logic [6:0]          r_dev_addr;
    logic [7:0]          r_quarter;
    logic                r_auto_inc;

    // sequencer state
    t_phase              r_phase,   n_phase;
    t_stage              r_stage,   n_stage;
    logic [3:0]          r_bit_cnt, n_bit_cnt;
    logic [BURST_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]          r_shift,   n_shift;
    logic [7:0]          r_delay,   n_delay;
    logic [BURST_W-1:0]  r_fill,    n_fill;
    logic                r_scl,     n_scl;
    logic                r_sda,     n_sda;
    logic                r_is_read, n_is_read;
    logic [7:0]          r_reg,     n_reg;
    logic [BURST_W-1:0]  r_burst,   n_burst;
    t_status             r_pend,    n_pend;

    // write byte queue
    logic [7:0]          r_wq [MAX_BURST];

    // result queue
    t_result             r_res_q [2];
    logic                r_res_wr;
    logic                r_res_rd;
    logic [1:0]          r_res_cnt;

    logic                w_take;
    logic                w_tick;
    logic                w_step;
    logic [8:0]          w_dly_inc;
    logic [7:0]          w_quarter;
    logic [BURST_W-1:0]  w_byte_inc;
    logic [BURST_W-1:0]  w_ld_cnt;
    logic [7:0]          w_ld_byte;
    logic                w_last_rd;
    logic                w_sda_in;
    logic                w_qwrite;
    logic                w_res_pop;
    t_result             w_res;

    assign w_res_pop  = i_res_pop && o_res_valid;
    assign o_take     = (r_res_cnt != 2'd2) || w_res_pop;
    assign w_take     = o_take && i_valid;
    assign w_sda_in   = i_item.sda;
    assign w_tick     = w_take && (i_item.cmd == CMD_TICK) && (r_phase != PH_IDLE);
    assign w_quarter  = (r_quarter == 8'd0) ? 8'd1 : r_quarter;
    assign w_dly_inc  = {1'b0, r_delay} + 9'd1;
    assign w_step     = w_tick && (w_dly_inc >= {1'b0, w_quarter});
    assign w_byte_inc = r_byte_cnt + BURST_W'(1);
    assign w_last_rd  = (w_byte_inc >= r_burst);
    assign w_qwrite   = w_take && (i_item.cmd == CMD_QUEUE) && (r_phase == PH_IDLE)
                        && (r_fill < BURST_W'(MAX_BURST));

    // next data byte: unqueued positions send zero
    assign w_ld_cnt  = (r_stage == STG_WDATA) ? w_byte_inc : r_byte_cnt;
    assign w_ld_byte = (w_ld_cnt < r_fill) ? r_wq[w_ld_cnt[QIDX_W-1:0]] : 8'h00;

    // next state of the sequencer
    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_bit_cnt  = r_bit_cnt;
        n_byte_cnt = r_byte_cnt;
        n_shift    = r_shift;
        n_delay    = r_delay;
        n_fill     = r_fill;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_is_read  = r_is_read;
        n_reg      = r_reg;
        n_burst    = r_burst;
        n_pend     = r_pend;

        if (w_qwrite) begin
            n_fill = r_fill + BURST_W'(1);
        end

        if (w_take && (r_phase == PH_IDLE)
                && ((i_item.cmd == CMD_WRITE) || (i_item.cmd == CMD_READ))) begin
            n_burst    = i_item.burst_len;
            n_reg      = i_item.reg_addr;
            n_is_read  = (i_item.cmd == CMD_READ);
            n_stage    = STG_ADDR_W;
            n_byte_cnt = '0;
            n_bit_cnt  = 4'd0;
            n_shift    = 8'h00;
            n_delay    = 8'd0;
            n_pend     = ST_OK;
            n_phase    = PH_START_A;
        end

        if (w_tick) begin
            n_delay = w_step ? 8'd0 : w_dly_inc[7:0];
        end

        if (w_step) begin
            case (r_phase)
                PH_START_A: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_START_B;
                end
                PH_START_B: begin
                    if (!w_sda_in) begin
                        if (r_stage == STG_ADDR_R) begin
                            n_pend  = ST_BUSY;
                            n_phase = PH_STOP_A;
                        end else begin
                            n_phase = PH_IDLE;
                            if (!r_is_read) n_fill = '0;
                        end
                    end else begin
                        n_sda   = 1'b0;
                        n_phase = PH_START_C;
                    end
                end
                PH_START_C: begin
                    if (w_sda_in) begin
                        if (r_stage == STG_ADDR_R) begin
                            n_pend  = ST_BUSY;
                            n_phase = PH_STOP_A;
                        end else begin
                            n_sda   = 1'b1;
                            n_phase = PH_IDLE;
                            if (!r_is_read) n_fill = '0;
                        end
                    end else begin
                        n_shift   = {r_dev_addr, (r_stage == STG_ADDR_R)};
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_BIT_LOW;
                    end
                end
                PH_BIT_LOW: begin
                    n_scl   = 1'b0;
                    n_phase = PH_BIT_SET;
                end
                PH_BIT_SET: begin
                    n_sda   = r_shift[7];
                    n_shift = {r_shift[6:0], 1'b0};
                    n_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    n_scl     = 1'b1;
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    n_phase   = (r_bit_cnt >= 4'd7) ? PH_ACK_LOW : PH_BIT_LOW;
                end
                PH_ACK_LOW: begin
                    n_scl   = 1'b0;
                    n_phase = PH_ACK_REL;
                end
                PH_ACK_REL: begin
                    n_sda   = 1'b1;
                    n_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    n_scl   = 1'b1;
                    n_phase = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    n_scl = 1'b0;
                    if (w_sda_in) begin
                        n_pend  = ST_NACK;
                        n_phase = PH_STOP_B;
                    end else begin
                        case (r_stage)
                            STG_ADDR_W: begin
                                n_stage   = STG_REG;
                                n_shift   = (r_is_read && r_auto_inc)
                                            ? (r_reg | AUTO_INC_MASK) : r_reg;
                                n_bit_cnt = 4'd0;
                                n_phase   = PH_BIT_LOW;
                            end
                            STG_REG: begin
                                if (r_is_read) begin
                                    n_stage = STG_ADDR_R;
                                    n_phase = PH_RS_SDA;
                                end else if (r_byte_cnt < r_burst) begin
                                    n_stage   = STG_WDATA;
                                    n_shift   = w_ld_byte;
                                    n_bit_cnt = 4'd0;
                                    n_phase   = PH_BIT_LOW;
                                end else begin
                                    n_pend  = ST_OK;
                                    n_phase = PH_STOP_B;
                                end
                            end
                            STG_ADDR_R: begin
                                n_stage   = STG_RDATA;
                                n_shift   = 8'h00;
                                n_bit_cnt = 4'd0;
                                n_phase   = PH_RB_LOW;
                            end
                            default: begin
                                n_byte_cnt = w_byte_inc;
                                if (w_byte_inc < r_burst) begin
                                    n_stage   = STG_WDATA;
                                    n_shift   = w_ld_byte;
                                    n_bit_cnt = 4'd0;
                                    n_phase   = PH_BIT_LOW;
                                end else begin
                                    n_pend  = ST_OK;
                                    n_phase = PH_STOP_B;
                                end
                            end
                        endcase
                    end
                end
                PH_RS_SDA: begin
                    n_sda   = 1'b1;
                    n_phase = PH_START_A;
                end
                PH_RB_LOW: begin
                    n_scl   = 1'b0;
                    n_sda   = 1'b1;
                    n_phase = PH_RB_HIGH;
                end
                PH_RB_HIGH: begin
                    n_scl   = 1'b1;
                    n_phase = PH_RB_SAMPLE;
                end
                PH_RB_SAMPLE: begin
                    n_shift   = {r_shift[6:0], w_sda_in};
                    n_bit_cnt = r_bit_cnt + 4'd1;
                    n_phase   = (r_bit_cnt < 4'd7) ? PH_RB_LOW : PH_AK_LOW;
                end
                PH_AK_LOW: begin
                    n_scl   = 1'b0;
                    n_phase = PH_AK_SET;
                end
                PH_AK_SET: begin
                    // nack on the final byte, ack otherwise
                    n_sda   = w_last_rd;
                    n_phase = PH_AK_HIGH;
                end
                PH_AK_HIGH: begin
                    n_scl   = 1'b1;
                    n_phase = PH_AK_END;
                end
                PH_AK_END: begin
                    n_scl      = 1'b0;
                    n_byte_cnt = w_byte_inc;
                    if (w_last_rd) begin
                        n_pend  = ST_OK;
                        n_phase = PH_STOP_B;
                    end else begin
                        n_shift   = 8'h00;
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_RB_LOW;
                    end
                end
                PH_STOP_A: begin
                    n_scl   = 1'b0;
                    n_phase = PH_STOP_B;
                end
                PH_STOP_B: begin
                    n_sda   = 1'b0;
                    n_phase = PH_STOP_C;
                end
                PH_STOP_C: begin
                    n_scl   = 1'b1;
                    n_phase = PH_STOP_D;
                end
                PH_STOP_D: begin
                    n_sda   = 1'b1;
                    n_phase = PH_IDLE;
                    if (!r_is_read) n_fill = '0;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result word for the item being taken
    always_comb begin
        w_res.scl    = n_scl;
        w_res.sda    = n_sda;
        w_res.busy   = (n_phase != PH_IDLE);
        w_res.rvalid = w_step && (r_phase == PH_RB_SAMPLE) && (r_bit_cnt >= 4'd7);
        w_res.rbyte  = w_res.rvalid ? {r_shift[6:0], w_sda_in} : 8'h00;
        w_res.last   = w_res.rvalid && w_last_rd;
        w_res.done   = 1'b0;
        w_res.status = ST_OK;
        if (w_step) begin
            case (r_phase)
                PH_STOP_D: begin
                    w_res.done   = 1'b1;
                    w_res.status = r_pend;
                end
                PH_START_B: begin
                    if (!w_sda_in && (r_stage != STG_ADDR_R)) begin
                        w_res.done   = 1'b1;
                        w_res.status = ST_BUSY;
                    end
                end
                PH_START_C: begin
                    if (w_sda_in && (r_stage != STG_ADDR_R)) begin
                        w_res.done   = 1'b1;
                        w_res.status = ST_BUSY;
                    end
                end
                default: begin
                    w_res.done = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 7'd0;
            r_quarter  <= 8'd1;
            r_auto_inc <= 1'b1;
            r_phase    <= PH_IDLE;
            r_stage    <= STG_ADDR_W;
            r_bit_cnt  <= 4'd0;
            r_byte_cnt <= '0;
            r_shift    <= 8'h00;
            r_delay    <= 8'd0;
            r_fill     <= '0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_is_read  <= 1'b0;
            r_reg      <= 8'h00;
            r_burst    <= '0;
            r_pend     <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEV_ADDR: r_dev_addr <= i_cfg_wdata[6:0];
                    CFG_QUARTER:  r_quarter  <= i_cfg_wdata;
                    CFG_AUTO_INC: r_auto_inc <= i_cfg_wdata[0];
                    default:      r_auto_inc <= r_auto_inc;
                endcase
            end
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_shift    <= n_shift;
            r_delay    <= n_delay;
            r_fill     <= n_fill;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_is_read  <= n_is_read;
            r_reg      <= n_reg;
            r_burst    <= n_burst;
            r_pend     <= n_pend;
        end
    end

    // write byte queue storage
    always_ff @(posedge i_clk) begin
        if (w_qwrite) begin
            r_wq[r_fill[QIDX_W-1:0]] <= i_item.wbyte;
        end
    end

    // result queue
    assign o_res_valid = (r_res_cnt != 2'd0);
    assign o_res       = r_res_q[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (w_take) r_res_wr <= ~r_res_wr;
            if (w_res_pop) r_res_rd <= ~r_res_rd;
            r_res_cnt <= r_res_cnt + {1'b0, w_take} - {1'b0, w_res_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res_q[r_res_wr] <= w_res;
        end
    end

endmodule
`default_nettype wire

[test/tb_i2c_master_register_access_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access_top
// Self-checking bench for the I2C register access master. Input words are
// built against a shadow copy of the bus sequencer, so that SDA answers
// (bus free, ack, read data) match what the bus would return, with faults
// injected on purpose. A second copy predicts every result word at the point
// of acceptance, and the result side compares each word field by field.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_top;
    import i2cm_pkg::*;

    // which bus fault the slave side plays during one transfer
    typedef enum logic [2:0] {
        FLT_NONE,
        FLT_BUSY_START,
        FLT_BUSY_PULL,
        FLT_BUSY_RESTART,
        FLT_NACK_ADDR,
        FLT_NACK_DATA,
        FLT_RANDOM
    } t_fault;

    // sequencer state plus configuration
    typedef struct packed {
        logic [6:0]                  dev;
        logic [7:0]                  qtr;
        logic                        ainc;
        t_phase                      ph;
        t_stage                      stg;
        logic [3:0]                  nbit;
        logic [4:0]                  nbyte;
        logic [7:0]                  shreg;
        logic [7:0]                  tick_cnt;
        logic [MAX_BURST-1:0][7:0]   wq;
        logic [4:0]                  wq_fill;
        logic                        scl;
        logic                        sda;
        logic                        rd;
        logic [7:0]                  reg_a;
        logic [4:0]                  blen;
        t_status                     pend;
    } t_bus_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_command = '0;
    logic        i_sda_in = 1'b0;
    logic [7:0]  i_reg_addr = '0;
    logic [4:0]  i_burst_length = '0;
    logic [7:0]  i_write_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_scl_out;
    logic        o_sda_out;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_last_byte;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic        o_busy_res;

    t_bus_state  shadow_bus;
    t_bus_state  predicted_bus;
    t_item       words_to_send[$];
    t_result     due_results[$];
    int          err_count = 0;
    int          work_count = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    bit          calm = 1'b0;

    i2c_master_register_access_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_sda_in       (i_sda_in),
        .i_reg_addr     (i_reg_addr),
        .i_burst_length (i_burst_length),
        .i_write_byte   (i_write_byte),
        .empty          (empty),
        .pop            (pop),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_read_byte    (o_read_byte),
        .o_read_valid   (o_read_valid),
        .o_last_byte    (o_last_byte),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_busy_res     (o_busy_res)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bus sequencer prediction
    // ------------------------------------------------------------------------
    function automatic void bus_reset(output t_bus_state m);
        m = '0;
        m.qtr = 8'd1;
        m.ainc = 1'b1;
        m.ph = PH_IDLE;
        m.stg = STG_ADDR_W;
        m.scl = 1'b1;
        m.sda = 1'b1;
        m.pend = ST_OK;
    endfunction

    function automatic void bus_set_reg(inout t_bus_state m, input logic [1:0] idx,
                                        input logic [7:0] val);
        case (idx)
            CFG_DEV_ADDR: m.dev = val[6:0];
            CFG_QUARTER:  m.qtr = val;
            CFG_AUTO_INC: m.ainc = val[0];
            default: ;
        endcase
    endfunction

    // a zero period runs like one
    function automatic logic [7:0] quarter_of(input t_bus_state m);
        return (m.qtr == 8'd0) ? 8'd1 : m.qtr;
    endfunction

    function automatic void bus_finish(inout t_bus_state m, inout t_result r,
                                       input t_status st);
        r.done = 1'b1;
        r.status = st;
        m.ph = PH_IDLE;
        if (!m.rd) m.wq_fill = '0;
    endfunction

    function automatic void send_byte(inout t_bus_state m, input logic [7:0] v);
        m.shreg = v;
        m.nbit = '0;
        m.ph = PH_BIT_LOW;
    endfunction

    // next write data byte, zero once the queue runs dry
    function automatic void send_write_data(inout t_bus_state m);
        logic [7:0] v;
        v = 8'h00;
        if (m.nbyte < m.wq_fill && m.nbyte < MAX_BURST) v = m.wq[m.nbyte[QIDX_W-1:0]];
        m.stg = STG_WDATA;
        send_byte(m, v);
    endfunction

    function automatic void send_stop(inout t_bus_state m, input t_status st);
        m.pend = st;
        m.ph = PH_STOP_B;
    endfunction

    // one pin change or one sample
    function automatic void bus_advance(inout t_bus_state m, inout t_result r,
                                        input logic sda_in);
        case (m.ph)
            PH_START_A: begin
                m.scl = 1'b1;
                m.sda = 1'b1;
                m.ph = PH_START_B;
            end
            PH_START_B: begin
                if (!sda_in) begin
                    if (m.stg == STG_ADDR_R) begin
                        m.pend = ST_BUSY;
                        m.ph = PH_STOP_A;
                    end else begin
                        bus_finish(m, r, ST_BUSY);
                    end
                end else begin
                    m.sda = 1'b0;
                    m.ph = PH_START_C;
                end
            end
            PH_START_C: begin
                if (sda_in) begin
                    if (m.stg == STG_ADDR_R) begin
                        m.pend = ST_BUSY;
                        m.ph = PH_STOP_A;
                    end else begin
                        m.sda = 1'b1;
                        bus_finish(m, r, ST_BUSY);
                    end
                end else if (m.stg == STG_ADDR_R) begin
                    send_byte(m, {m.dev, 1'b1});
                end else begin
                    send_byte(m, {m.dev, 1'b0});
                end
            end
            PH_BIT_LOW: begin
                m.scl = 1'b0;
                m.ph = PH_BIT_SET;
            end
            PH_BIT_SET: begin
                m.sda = m.shreg[7];
                m.shreg = {m.shreg[6:0], 1'b0};
                m.ph = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                m.scl = 1'b1;
                m.nbit = m.nbit + 4'd1;
                if (m.nbit >= 4'd8) m.ph = PH_ACK_LOW;
                else m.ph = PH_BIT_LOW;
            end
            PH_ACK_LOW: begin
                m.scl = 1'b0;
                m.ph = PH_ACK_REL;
            end
            PH_ACK_REL: begin
                m.sda = 1'b1;
                m.ph = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                m.scl = 1'b1;
                m.ph = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE: begin
                m.scl = 1'b0;
                if (sda_in) begin
                    send_stop(m, ST_NACK);
                end else if (m.stg == STG_ADDR_W) begin
                    m.stg = STG_REG;
                    send_byte(m, m.reg_a | ((m.rd && m.ainc) ? AUTO_INC_MASK : 8'h00));
                end else if (m.stg == STG_REG) begin
                    if (m.rd) begin
                        m.stg = STG_ADDR_R;
                        m.ph = PH_RS_SDA;
                    end else if (m.nbyte < m.blen) begin
                        send_write_data(m);
                    end else begin
                        send_stop(m, ST_OK);
                    end
                end else if (m.stg == STG_ADDR_R) begin
                    m.stg = STG_RDATA;
                    m.shreg = '0;
                    m.nbit = '0;
                    m.ph = PH_RB_LOW;
                end else begin
                    m.nbyte = m.nbyte + 5'd1;
                    if (m.nbyte < m.blen) send_write_data(m);
                    else send_stop(m, ST_OK);
                end
            end
            PH_RS_SDA: begin
                m.sda = 1'b1;
                m.ph = PH_START_A;
            end
            PH_RB_LOW: begin
                m.scl = 1'b0;
                m.sda = 1'b1;
                m.ph = PH_RB_HIGH;
            end
            PH_RB_HIGH: begin
                m.scl = 1'b1;
                m.ph = PH_RB_SAMPLE;
            end
            PH_RB_SAMPLE: begin
                m.shreg = {m.shreg[6:0], sda_in};
                m.nbit = m.nbit + 4'd1;
                if (m.nbit < 4'd8) begin
                    m.ph = PH_RB_LOW;
                end else begin
                    r.rvalid = 1'b1;
                    r.rbyte = m.shreg;
                    r.last = (m.nbyte + 5'd1 >= m.blen);
                    m.ph = PH_AK_LOW;
                end
            end
            PH_AK_LOW: begin
                m.scl = 1'b0;
                m.ph = PH_AK_SET;
            end
            // nack on the final byte, ack otherwise
            PH_AK_SET: begin
                m.sda = (m.nbyte + 5'd1 >= m.blen);
                m.ph = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
                m.scl = 1'b1;
                m.ph = PH_AK_END;
            end
            PH_AK_END: begin
                m.scl = 1'b0;
                m.nbyte = m.nbyte + 5'd1;
                if (m.nbyte >= m.blen) begin
                    send_stop(m, ST_OK);
                end else begin
                    m.shreg = '0;
                    m.nbit = '0;
                    m.ph = PH_RB_LOW;
                end
            end
            PH_STOP_A: begin
                m.scl = 1'b0;
                m.ph = PH_STOP_B;
            end
            PH_STOP_B: begin
                m.sda = 1'b0;
                m.ph = PH_STOP_C;
            end
            PH_STOP_C: begin
                m.scl = 1'b1;
                m.ph = PH_STOP_D;
            end
            PH_STOP_D: begin
                m.sda = 1'b1;
                bus_finish(m, r, m.pend);
            end
            default: m.ph = PH_IDLE;
        endcase
    endfunction

    // one input word in, one result word out
    function automatic void bus_take_word(inout t_bus_state m, input t_item it,
                                          output t_result r);
        logic [4:0] len;
        r = '0;
        if (it.cmd == CMD_TICK) begin
            if (m.ph != PH_IDLE) begin
                m.tick_cnt = m.tick_cnt + 8'd1;
                if (m.tick_cnt >= quarter_of(m)) begin
                    m.tick_cnt = '0;
                    bus_advance(m, r, it.sda);
                end
            end
        end else if (m.ph == PH_IDLE) begin
            if (it.cmd == CMD_QUEUE) begin
                if (m.wq_fill < MAX_BURST) begin
                    m.wq[m.wq_fill[QIDX_W-1:0]] = it.wbyte;
                    m.wq_fill = m.wq_fill + 5'd1;
                end
            end else begin
                len = it.burst_len;
                if (len == 5'd0) len = 5'd1;
                if (len > MAX_BURST) len = 5'(MAX_BURST);
                m.blen = len;
                m.reg_a = it.reg_addr;
                m.rd = (it.cmd == CMD_READ);
                m.stg = STG_ADDR_W;
                m.nbyte = '0;
                m.nbit = '0;
                m.shreg = '0;
                m.tick_cnt = '0;
                m.pend = ST_OK;
                m.ph = PH_START_A;
            end
        end
        r.scl = m.scl;
        r.sda = m.sda;
        r.busy = (m.ph != PH_IDLE);
    endfunction

    // ------------------------------------------------------------------------
    // word building
    // ------------------------------------------------------------------------
    function automatic t_item rand_item();
        t_item it;
        it.cmd = t_cmd'($urandom_range(0, 3));
        it.sda = $urandom_range(0, 1);
        it.reg_addr = $urandom;
        it.burst_len = $urandom;
        it.wbyte = $urandom;
        return it;
    endfunction

    // words that the block acts on count towards the phase target
    task automatic push_item(input t_item it);
        t_result unused;
        if ((it.cmd == CMD_TICK) == (shadow_bus.ph != PH_IDLE)) work_count++;
        bus_take_word(shadow_bus, it, unused);
        words_to_send.push_back(it);
    endtask

    task automatic queue_byte(input logic [7:0] wb);
        t_item it;
        it = rand_item();
        it.cmd = CMD_QUEUE;
        it.wbyte = wb;
        push_item(it);
    endtask

    task automatic start_burst(input t_cmd c, input logic [7:0] ra, input logic [4:0] len);
        t_item it;
        it = rand_item();
        it.cmd = c;
        it.reg_addr = ra;
        it.burst_len = len;
        push_item(it);
    endtask

    // tick words until the transfer ends, with SDA as the slave would leave it
    task automatic tick_to_idle(input t_fault fault);
        t_item it;
        logic  flip;
        logic  stray;
        while (shadow_bus.ph != PH_IDLE) begin
            it = rand_item();
            it.cmd = CMD_TICK;
            flip = (fault == FLT_RANDOM) && ($urandom_range(0, 99) < 4);
            stray = (fault == FLT_RANDOM) && ($urandom_range(0, 99) < 3);
            if (int'(shadow_bus.tick_cnt) + 1 >= int'(quarter_of(shadow_bus))) begin
                case (shadow_bus.ph)
                    PH_START_B: it.sda = flip ^ !((fault == FLT_BUSY_START &&
                                                   shadow_bus.stg != STG_ADDR_R) ||
                                                  (fault == FLT_BUSY_RESTART &&
                                                   shadow_bus.stg == STG_ADDR_R));
                    PH_START_C: it.sda = flip ^ (fault == FLT_BUSY_PULL);
                    PH_ACK_SAMPLE: it.sda = flip ^ ((fault == FLT_NACK_ADDR &&
                                                     shadow_bus.stg == STG_ADDR_W) ||
                                                    (fault == FLT_NACK_DATA &&
                                                     shadow_bus.stg == STG_WDATA));
                    default: ;
                endcase
            end
            // commands while busy are dropped by the block
            if (stray) it.cmd = t_cmd'($urandom_range(1, 3));
            push_item(it);
        end
    endtask

    // wait until every word has gone through and the pipeline has emptied
    task automatic settle();
        while (words_to_send.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bus_set_reg(shadow_bus, idx, val);
        bus_set_reg(predicted_bus, idx, val);
    endtask

    task automatic configure(input logic [6:0] dev, input logic [7:0] qtr, input logic ainc);
        settle();
        write_reg(CFG_DEV_ADDR, {1'b0, dev});
        write_reg(CFG_QUARTER, qtr);
        write_reg(CFG_AUTO_INC, {7'd0, ainc});
        @(negedge i_clk);
    endtask

    // queued bytes, a burst of random length and direction, run to the end
    task automatic random_phase(input int target);
        t_item it;
        int    nq;
        logic  [4:0] len;
        work_count = 0;
        while (work_count < target) begin
            repeat ($urandom_range(0, 3)) begin
                it = rand_item();
                it.cmd = CMD_TICK;
                push_item(it);
            end
            nq = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
            repeat (nq) queue_byte($urandom);
            len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 3));
            start_burst(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE, $urandom, len);
            tick_to_idle(FLT_RANDOM);
        end
    endtask

    // ------------------------------------------------------------------------
    // input side: present the next word, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_item   cur;
        t_result res;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                cur.cmd = t_cmd'(i_command);
                cur.sda = i_sda_in;
                cur.reg_addr = i_reg_addr;
                cur.burst_len = i_burst_length;
                cur.wbyte = i_write_byte;
                bus_take_word(predicted_bus, cur, res);
                due_results.push_back(res);
                words_to_send.delete(0);
            end
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 6) begin
                send_gap = $urandom_range(0, 12);
                push <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                push <= 1'b1;
                i_command <= words_to_send[0].cmd;
                i_sda_in <= words_to_send[0].sda;
                i_reg_addr <= words_to_send[0].reg_addr;
                i_burst_length <= words_to_send[0].burst_len;
                i_write_byte <= words_to_send[0].wbyte;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: stall at random, compare each word taken
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            if (err_count < 40)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    if (err_count < 40)
                        $display("%0t ns: result word with none expected", $time);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("scl_out", want.scl, o_scl_out);
                    check_field("sda_out", want.sda, o_sda_out);
                    check_field("read_byte", want.rbyte, o_read_byte);
                    check_field("read_valid", want.rvalid, o_read_valid);
                    check_field("last_byte", want.last, o_last_byte);
                    check_field("done_res", want.done, o_done_res);
                    check_field("status", want.status, o_status);
                    check_field("busy_res", want.busy, o_busy_res);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 6) begin
                take_gap = $urandom_range(0, 12);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_item it;
        bus_reset(shadow_bus);
        bus_reset(predicted_bus);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both burst kinds and each bus fault
        configure(7'd0, 8'd1, 1'b1);
        it = rand_item();
        it.cmd = CMD_TICK;
        push_item(it);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        start_burst(CMD_WRITE, 8'h00, 5'd2);
        // dropped while the transfer runs
        queue_byte(8'hA5);
        start_burst(CMD_READ, 8'h33, 5'd4);
        tick_to_idle(FLT_NONE);
        // auto increment bit on the register byte
        start_burst(CMD_READ, 8'h7F, 5'd1);
        tick_to_idle(FLT_NONE);
        // zero length saturates to one, empty queue sends zero
        start_burst(CMD_WRITE, 8'hFF, 5'd0);
        tick_to_idle(FLT_NONE);
        // long read saturates and leaves the queued byte for the write after
        queue_byte(8'h3C);
        start_burst(CMD_READ, 8'h40, 5'd31);
        tick_to_idle(FLT_NONE);
        start_burst(CMD_WRITE, 8'h01, 5'd3);
        tick_to_idle(FLT_NONE);
        start_burst(CMD_WRITE, 8'h10, 5'd1);
        tick_to_idle(FLT_BUSY_START);
        start_burst(CMD_READ, 8'h20, 5'd2);
        tick_to_idle(FLT_BUSY_PULL);
        start_burst(CMD_READ, 8'h21, 5'd2);
        tick_to_idle(FLT_BUSY_RESTART);
        start_burst(CMD_WRITE, 8'h22, 5'd1);
        tick_to_idle(FLT_NACK_ADDR);
        queue_byte(8'h81);
        queue_byte(8'h7E);
        start_burst(CMD_WRITE, 8'h23, 5'd2);
        tick_to_idle(FLT_NACK_DATA);

        // random traffic over several settings
        configure(7'd127, 8'd1, 1'b0);
        random_phase(220);

        // zero period, overfull queue and a full length write
        configure($urandom_range(0, 127), 8'd0, 1'b1);
        repeat (17) queue_byte($urandom);
        start_burst(CMD_WRITE, $urandom, 5'd20);
        tick_to_idle(FLT_NONE);

        // slowest period, cut short by a busy bus
        configure($urandom_range(0, 127), 8'd255, 1'b0);
        start_burst(CMD_WRITE, $urandom, 5'd1);
        tick_to_idle(FLT_BUSY_START);

        configure($urandom_range(0, 127), 8'd2, 1'b1);
        random_phase(200);

        // last stretch at full rate on both sides
        calm = 1'b1;
        configure($urandom_range(0, 127), 8'd1, $urandom_range(0, 1));
        random_phase(230);

        settle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
